// ===== rtl/nsc_pkg.sv =====
`default_nettype none

package nsc_pkg;

   localparam int CharWidth  = 8;
   localparam int SigWidth   = 5;
   localparam int LimDigits  = 20;
   localparam int LimWidth   = 4 * LimDigits;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 32;

   localparam logic [SigWidth-1:0] SigSat = 5'd21;

   localparam logic [CsrAddrWidth-1:0] CSR_ADDR_WORD_IS_64 = 2'd0;

   // limit magnitudes as bcd, most significant digit first, left aligned
   localparam logic [LimWidth-1:0] LIM_U64 = 80'h18446744073709551615;
   localparam logic [LimWidth-1:0] LIM_N64 = {76'h9223372036854775808, 4'h0};
   localparam logic [LimWidth-1:0] LIM_U32 = {40'h4294967295, 40'h0};
   localparam logic [LimWidth-1:0] LIM_N32 = {40'h2147483648, 40'h0};

   typedef enum logic [8:0] {
      PH_START    = 9'b000000001,
      PH_SIGN     = 9'b000000010,
      PH_ZEROS    = 9'b000000100,
      PH_INT      = 9'b000001000,
      PH_DOT      = 9'b000010000,
      PH_EXP_E    = 9'b000100000,
      PH_EXP_SIGN = 9'b001000000,
      PH_EXP_DIG  = 9'b010000000,
      PH_BAD      = 9'b100000000
   } nsc_phase_type;

   typedef enum logic [1:0] {
      CMP_EQ = 2'd0,
      CMP_LT = 2'd1,
      CMP_GT = 2'd2
   } nsc_cmp_type;

   typedef enum logic [2:0] {
      CLS_UNSIGNED = 3'd0,
      CLS_NEGATIVE = 3'd1,
      CLS_BIG      = 3'd2,
      CLS_FLOAT    = 3'd3,
      CLS_INVALID  = 3'd4
   } nsc_class_type;

   typedef struct packed {
      logic [CharWidth-1:0] ch;
      logic                 has_char;
      logic                 last;
   } nsc_item_type;

   typedef struct packed {
      nsc_class_type num_class;
      logic          negative;
   } nsc_result_type;

   function automatic logic [SigWidth-1:0] limit_len(input logic word_is_64,
                                                     input logic neg);
      logic [SigWidth-1:0] len;
      if (word_is_64) begin
         len = neg ? 5'd19 : 5'd20;
      end else begin
         len = 5'd10;
      end
      return len;
   endfunction

   function automatic logic [3:0] limit_digit(input logic word_is_64,
                                              input logic neg,
                                              input logic [SigWidth-1:0] idx);
      logic [LimWidth-1:0] vec;
      logic [LimWidth-1:0] shifted;
      logic [SigWidth-1:0] pos;
      if (word_is_64) begin
         vec = neg ? LIM_N64 : LIM_U64;
      end else begin
         vec = neg ? LIM_N32 : LIM_U32;
      end
      pos = (idx >= SigWidth'(LimDigits)) ? '0 : idx;
      shifted = vec << {pos, 2'b00};
      return shifted[LimWidth-1 -: 4];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/numeric_string_classifier.sv =====
// Numeric literal classifier. A string streams in one character per transaction on
// req_ (tdata = character, tuser = has_char, tlast = final character); when the
// transaction with tlast arrives, one result appears on rsp_ with the class in
// tdata[2:0] (0 unsigned fits, 1 negative fits, 2 big integer, 3 float, 4 invalid)
// and the sign flag for big and float in tuser. A character is taken every cycle,
// but a final character waits while the result register is full and rsp_tready
// is low: one input register feeds a single pass of lexer state update and range
// check into the result register, and strings may follow each other with no gap.
// Register word_is_64 at address 0 (reset 1) selects 64-bit or 32-bit integer
// limits; write it only while no string is in flight.
`default_nettype none

module numeric_string_classifier (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,   // ch
   input  wire logic [0:0]                       req_tuser,   // has_char
   input  wire logic                             req_tlast,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [7:0]                       rsp_tdata,   // num_class, zero pad
   output logic      [0:0]                       rsp_tuser,   // negative
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [nsc_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [nsc_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic      [nsc_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                                  csr_pready
);
   import nsc_pkg::*;

   logic           in_valid_ff, in_valid_in;
   nsc_item_type   item_ff, item_in;
   logic           rsp_valid_ff, rsp_valid_in;
   nsc_result_type rsp_ff, rsp_in;
   nsc_result_type result;
   logic           word_is_64;
   logic           advance;
   logic           req_take;

   nsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .word_is_64  (word_is_64)
   );

   nsc_lexer u_lexer (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (item_ff),
      .word_is_64 (word_is_64),
      .result     (result)
   );

   // a character without tlast never waits on the result side
   assign advance    = in_valid_ff && (!item_ff.last || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign item_in     = req_take
                        ? nsc_item_type'{ch: req_tdata, has_char: req_tuser[0],
                                         last: req_tlast}
                        : item_ff;

   assign rsp_valid_in = (advance && item_ff.last) || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = (advance && item_ff.last) ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {5'b0, rsp_ff.num_class};
   assign rsp_tuser[0] = rsp_ff.negative;

   assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.last) |=> rsp_valid_ff)
      else $error("final character did not produce a result");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(item_ff)))
      else $error("held character lost or changed");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !item_ff.last) |-> req_tready)
      else $error("non-final character stalled input");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.negative) |->
         (rsp_ff.num_class == CLS_BIG || rsp_ff.num_class == CLS_FLOAT))
      else $error("sign flag on a class that carries none");

endmodule

`default_nettype wire

// ===== rtl/nsc_csr.sv =====
`default_nettype none

module nsc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [nsc_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  wire logic [nsc_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic      [nsc_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                     csr_pready,
   output logic                                     word_is_64
);
   import nsc_pkg::*;

   logic word_is_64_ff;
   logic word_is_64_in;
   logic wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr == CSR_ADDR_WORD_IS_64);
   assign word_is_64_in = wr_hit ? csr_pwdata[0] : word_is_64_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_is_64_ff <= 1'b1;
      end else begin
         word_is_64_ff <= word_is_64_in;
      end
   end

   assign csr_prdata = (csr_paddr == CSR_ADDR_WORD_IS_64)
                       ? {{(CsrDataWidth-1){1'b0}}, word_is_64_ff} : '0;
   assign word_is_64 = word_is_64_ff;

endmodule

`default_nettype wire

// ===== rtl/nsc_lexer.sv =====
`default_nettype none

module nsc_lexer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire nsc_pkg::nsc_item_type item,
   input  wire logic                  word_is_64,
   output nsc_pkg::nsc_result_type    result
);
   import nsc_pkg::*;

   nsc_phase_type       phase_ff, phase_in, phase_upd;
   logic                neg_ff, neg_in, neg_upd;
   logic                zeros_ff, zeros_in, zeros_upd;
   logic [SigWidth-1:0] sig_ff, sig_in, sig_upd;
   nsc_cmp_type         cmp_ff, cmp_in, cmp_upd;
   logic                frac_ff, frac_in, frac_upd;

   logic                is_dig, is_e, is_s, has_int, take_digit;
   logic [SigWidth-1:0] dig_len, fin_len;
   logic [3:0]          lim_dig;
   logic [3:0]          dig_val;

   assign is_dig  = item.ch inside {[8'h30:8'h39]};
   assign is_e    = item.ch inside {8'h65, 8'h45};
   assign is_s    = item.ch inside {8'h2b, 8'h2d};
   assign has_int = zeros_ff || (sig_ff != '0);
   assign dig_val = item.ch[3:0];
   assign dig_len = limit_len(word_is_64, neg_ff);
   assign lim_dig = limit_digit(word_is_64, neg_ff, sig_ff);

   always_comb begin
      phase_upd  = phase_ff;
      neg_upd    = neg_ff;
      zeros_upd  = zeros_ff;
      sig_upd    = sig_ff;
      cmp_upd    = cmp_ff;
      frac_upd   = frac_ff;
      take_digit = 1'b0;
      if (item.has_char) begin
         case (phase_ff)
            PH_START, PH_SIGN: begin
               if (is_s && (phase_ff == PH_START)) begin
                  neg_upd   = (item.ch == 8'h2d);
                  phase_upd = PH_SIGN;
               end else if (item.ch == 8'h30) begin
                  zeros_upd = 1'b1;
                  phase_upd = PH_ZEROS;
               end else if (is_dig) begin
                  take_digit = 1'b1;
                  phase_upd  = PH_INT;
               end else if (item.ch == 8'h2e) begin
                  phase_upd = PH_DOT;
               end else begin
                  phase_upd = PH_BAD;
               end
            end
            PH_ZEROS, PH_INT: begin
               if ((item.ch == 8'h30) && (phase_ff == PH_ZEROS)) begin
                  phase_upd = PH_ZEROS;
               end else if (is_dig) begin
                  take_digit = 1'b1;
                  phase_upd  = PH_INT;
               end else if (item.ch == 8'h2e) begin
                  phase_upd = PH_DOT;
               end else if (is_e) begin
                  phase_upd = PH_EXP_E;
               end else begin
                  phase_upd = PH_BAD;
               end
            end
            PH_DOT: begin
               if (is_dig) begin
                  frac_upd = 1'b1;
               end else if (is_e && (has_int || frac_ff)) begin
                  phase_upd = PH_EXP_E;
               end else begin
                  phase_upd = PH_BAD;
               end
            end
            PH_EXP_E: begin
               if (is_s) begin
                  phase_upd = PH_EXP_SIGN;
               end else if (is_dig) begin
                  phase_upd = PH_EXP_DIG;
               end else begin
                  phase_upd = PH_BAD;
               end
            end
            PH_EXP_SIGN, PH_EXP_DIG: begin
               phase_upd = is_dig ? PH_EXP_DIG : PH_BAD;
            end
            default: begin
               phase_upd = PH_BAD;
            end
         endcase
      end
      if (take_digit) begin
         if ((sig_ff < dig_len) && (cmp_ff == CMP_EQ)) begin
            if (dig_val > lim_dig) begin
               cmp_upd = CMP_GT;
            end else if (dig_val < lim_dig) begin
               cmp_upd = CMP_LT;
            end
         end
         if (sig_ff < SigSat) begin
            sig_upd = sig_ff + 5'd1;
         end
      end
   end

   // classification of the string as it stands after this character
   assign fin_len = limit_len(word_is_64, neg_upd);

   always_comb begin
      result.num_class = CLS_INVALID;
      result.negative  = 1'b0;
      case (phase_upd)
         PH_START, PH_ZEROS: begin
            result.num_class = CLS_UNSIGNED;
         end
         PH_INT: begin
            if ((sig_upd > fin_len) || ((sig_upd == fin_len) && (cmp_upd == CMP_GT))) begin
               result.num_class = CLS_BIG;
               result.negative  = neg_upd;
            end else begin
               result.num_class = neg_upd ? CLS_NEGATIVE : CLS_UNSIGNED;
            end
         end
         PH_DOT: begin
            if (zeros_upd || (sig_upd != '0) || frac_upd) begin
               result.num_class = CLS_FLOAT;
               result.negative  = neg_upd;
            end
         end
         PH_EXP_DIG: begin
            result.num_class = CLS_FLOAT;
            result.negative  = neg_upd;
         end
         default: begin
            result.num_class = CLS_INVALID;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      zeros_in = zeros_ff;
      sig_in   = sig_ff;
      cmp_in   = cmp_ff;
      frac_in  = frac_ff;
      if (advance) begin
         if (item.last) begin
            phase_in = PH_START;
            neg_in   = 1'b0;
            zeros_in = 1'b0;
            sig_in   = '0;
            cmp_in   = CMP_EQ;
            frac_in  = 1'b0;
         end else begin
            phase_in = phase_upd;
            neg_in   = neg_upd;
            zeros_in = zeros_upd;
            sig_in   = sig_upd;
            cmp_in   = cmp_upd;
            frac_in  = frac_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         neg_ff   <= 1'b0;
         zeros_ff <= 1'b0;
         sig_ff   <= '0;
         cmp_ff   <= CMP_EQ;
         frac_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         zeros_ff <= zeros_in;
         sig_ff   <= sig_in;
         cmp_ff   <= cmp_in;
         frac_ff  <= frac_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) sig_ff <= SigSat)
      else $error("significant digit count past saturation");

endmodule

`default_nettype wire
